@@ rtl/ldpag_pkg.sv @@
// ----------------------------------------------------------------------------
// ldpag_pkg
// Shared types, register indexes and helper functions for the LFSR dissolve
// pixel address generator.
// ----------------------------------------------------------------------------
package ldpag_pkg;

   localparam int DIM_BITS = 12;
   localparam int ST_W     = 2 * DIM_BITS;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CNT_W    = $clog2(DIM_BITS + 1);
   localparam int TOT_W    = $clog2(ST_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLACE_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLACE_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   typedef struct packed {
      logic [DIM_BITS-1:0] src_width;
      logic [DIM_BITS-1:0] src_height;
      logic signed [12:0]  place_x;
      logic signed [12:0]  place_y;
      logic [12:0]         screen_width;
      logic [12:0]         screen_height;
   } cfg_type;

   // one decoded tick, handed from the front to the back
   typedef struct packed {
      logic                busy;
      logic                last;
      logic                pixel;
      logic [DIM_BITS-1:0] row;
      logic [DIM_BITS-1:0] col;
   } cmd_type;

   function automatic logic [CNT_W-1:0] bits_needed(input logic [DIM_BITS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < DIM_BITS; i++) begin
         if (v[i]) n = CNT_W'(i + 1);
      end
      return n;
   endfunction

   // maximal-length Galois tap masks, indexed by register length
   function automatic logic [ST_W-1:0] tap_mask(input logic [TOT_W-1:0] len);
      logic [ST_W-1:0] t;
      unique case (len)
         5'd2:    t = 24'h000003;
         5'd3:    t = 24'h000006;
         5'd4:    t = 24'h00000C;
         5'd5:    t = 24'h000014;
         5'd6:    t = 24'h000030;
         5'd7:    t = 24'h000060;
         5'd8:    t = 24'h0000B8;
         5'd9:    t = 24'h000110;
         5'd10:   t = 24'h000240;
         5'd11:   t = 24'h000500;
         5'd12:   t = 24'h000CA0;
         5'd13:   t = 24'h001B00;
         5'd14:   t = 24'h003500;
         5'd15:   t = 24'h006000;
         5'd16:   t = 24'h00B400;
         5'd17:   t = 24'h012000;
         5'd18:   t = 24'h020400;
         5'd19:   t = 24'h072000;
         5'd20:   t = 24'h090000;
         5'd21:   t = 24'h140000;
         5'd22:   t = 24'h300000;
         5'd23:   t = 24'h400000;
         5'd24:   t = 24'hD80000;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/ldpag_front.sv @@
// ----------------------------------------------------------------------------
// ldpag_front
// Takes restart/advance beats, runs the sequence phase and the LFSR, and
// pushes one decoded pixel command per beat.
// ----------------------------------------------------------------------------
module ldpag_front (
   input  logic               clock,
   input  logic               reset,
   input  ldpag_pkg::cfg_type cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   input  logic               q_ready,
   output logic               q_push,
   output ldpag_pkg::cmd_type q_cmd
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RUN   = 2'd1,
      PH_FINAL = 2'd2
   } phase_type;

   phase_type                      phase_ff, phase_in, phase_cur;
   logic [ldpag_pkg::ST_W-1:0]     shift_ff, shift_in;
   logic [ldpag_pkg::ST_W-1:0]     st_cur, e, stepped, regmask, taps;
   logic [ldpag_pkg::CNT_W-1:0]    rw, cw;
   logic [ldpag_pkg::TOT_W-1:0]    total;
   logic [ldpag_pkg::ST_W:0]       mask_wide;
   logic [ldpag_pkg::DIM_BITS:0]   col_mask;
   logic                           empty;

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   always_comb begin
      rw        = ldpag_pkg::bits_needed(cfg.src_height);
      cw        = ldpag_pkg::bits_needed(cfg.src_width);
      total     = ldpag_pkg::TOT_W'(rw) + ldpag_pkg::TOT_W'(cw);
      mask_wide = ((ldpag_pkg::ST_W+1)'(1) << total) - (ldpag_pkg::ST_W+1)'(1);
      regmask   = mask_wide[ldpag_pkg::ST_W-1:0];
      taps      = ldpag_pkg::tap_mask(total);
      col_mask  = ((ldpag_pkg::DIM_BITS+1)'(1) << cw) - (ldpag_pkg::DIM_BITS+1)'(1);
      empty     = (cfg.src_width == '0) || (cfg.src_height == '0);

      if (req_restart) begin
         st_cur    = ldpag_pkg::ST_W'(1);
         phase_cur = empty ? PH_FINAL : PH_RUN;
      end else begin
         st_cur    = shift_ff;
         phase_cur = phase_ff;
      end

      e       = st_cur & regmask;
      stepped = (e[0] ? ((e >> 1) ^ taps) : (e >> 1)) & regmask;

      q_cmd       = '0;
      shift_in    = st_cur;
      phase_in    = PH_IDLE;
      unique case (phase_cur)
         PH_RUN: begin
            q_cmd.busy  = 1'b1;
            q_cmd.pixel = 1'b1;
            q_cmd.row   = ldpag_pkg::DIM_BITS'(e >> cw);
            q_cmd.col   = e[ldpag_pkg::DIM_BITS-1:0] & col_mask[ldpag_pkg::DIM_BITS-1:0];
            shift_in    = stepped;
            phase_in    = (stepped == ldpag_pkg::ST_W'(1)) ? PH_FINAL : PH_RUN;
         end
         PH_FINAL: begin
            // pixel (0,0) is never visited by the LFSR; an empty image writes nothing
            q_cmd.busy  = 1'b1;
            q_cmd.last  = 1'b1;
            q_cmd.pixel = !empty;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
      end else if (q_push) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
      end
   end

endmodule

@@ rtl/ldpag_queue.sv @@
// ----------------------------------------------------------------------------
// ldpag_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ldpag_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ldpag_pkg::cmd_type push_cmd,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output ldpag_pkg::cmd_type head_cmd
);

   ldpag_pkg::cmd_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/ldpag_back.sv @@
// ----------------------------------------------------------------------------
// ldpag_back
// Clips a pixel command against image and screen, forms the source index
// and target address, and holds the result beat until taken.
// ----------------------------------------------------------------------------
module ldpag_back (
   input  logic               clock,
   input  logic               reset,
   input  ldpag_pkg::cfg_type cfg,
   input  logic               q_not_empty,
   input  ldpag_pkg::cmd_type q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_write_enable,
   output logic [23:0]        rsp_source_index,
   output logic [11:0]        rsp_target_x,
   output logic [11:0]        rsp_target_y,
   output logic               rsp_last,
   output logic               rsp_busy_res
);

   logic               valid_ff;
   logic               we_ff, we_in;
   logic [23:0]        index_ff, index_in;
   logic [11:0]        tx_ff, tx_in, ty_ff, ty_in;
   logic               last_ff, busy_ff;
   logic signed [14:0] tx, ty;
   logic [23:0]        prod;
   logic               x_ok, y_ok;

   assign q_pop = q_not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      tx   = 15'(cfg.place_x) + $signed({3'b000, q_cmd.col});
      ty   = 15'(cfg.place_y) + $signed({3'b000, q_cmd.row});
      prod = q_cmd.row * cfg.src_width;
      // on screen: not negative, no wider than 12 bits, below the screen size
      x_ok = !tx[14] && (tx[13:12] == 2'b00) && ({1'b0, tx[11:0]} < cfg.screen_width);
      y_ok = !ty[14] && (ty[13:12] == 2'b00) && ({1'b0, ty[11:0]} < cfg.screen_height);
      we_in = q_cmd.pixel && (q_cmd.row < cfg.src_height) &&
              (q_cmd.col < cfg.src_width) && x_ok && y_ok;
      index_in = we_in ? (prod + 24'(q_cmd.col)) : '0;
      tx_in    = we_in ? tx[11:0] : '0;
      ty_in    = we_in ? ty[11:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         we_ff    <= we_in;
         index_ff <= index_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         last_ff  <= q_cmd.last;
         busy_ff  <= q_cmd.busy;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_source_index = index_ff;
   assign rsp_target_x     = tx_ff;
   assign rsp_target_y     = ty_ff;
   assign rsp_last         = last_ff;
   assign rsp_busy_res     = busy_ff;

endmodule

@@ rtl/lfsr_dissolve_pixel_address_generator_core.sv @@
// ----------------------------------------------------------------------------
// lfsr_dissolve_pixel_address_generator_core
// Pseudo-random pixel order for a dissolve: LFSR front, two-entry queue,
// clip and address back end.
// ----------------------------------------------------------------------------
// Every request beat (restart or advance) yields exactly one response beat.
// The block takes one beat per cycle while the queue has room; the sustained
// rate is one pixel per clock while rsp_ready holds, with a combinational LFSR
// step in the front and the registered multiply-add in the back. A two-entry
// queue lets either side stall on its own. Registers are written through the
// csr_ port (index 0 image width, 1 image height, 2 place x, 3 place y, 4
// screen width, 5 screen height) and are used live on every tick.
module lfsr_dissolve_pixel_address_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_enable,
   output logic [23:0] rsp_source_index,
   output logic [11:0] rsp_target_x,
   output logic [11:0] rsp_target_y,
   output logic        rsp_last,
   output logic        rsp_busy_res
);

   ldpag_pkg::cfg_type cfg_ff;
   ldpag_pkg::cmd_type push_cmd, head_cmd;
   logic               q_push, q_pop, q_not_full, q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width     <= 12'd1;
         cfg_ff.src_height    <= 12'd1;
         cfg_ff.place_x       <= 13'sd0;
         cfg_ff.place_y       <= 13'sd0;
         cfg_ff.screen_width  <= 13'd320;
         cfg_ff.screen_height <= 13'd240;
      end else if (csr_we) begin
         unique case (csr_index)
            ldpag_pkg::CSR_SRC_WIDTH:     cfg_ff.src_width     <= csr_wdata[11:0];
            ldpag_pkg::CSR_SRC_HEIGHT:    cfg_ff.src_height    <= csr_wdata[11:0];
            ldpag_pkg::CSR_PLACE_X:       cfg_ff.place_x       <= $signed(csr_wdata);
            ldpag_pkg::CSR_PLACE_Y:       cfg_ff.place_y       <= $signed(csr_wdata);
            ldpag_pkg::CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata;
            ldpag_pkg::CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata;
            default: ;
         endcase
      end
   end

   ldpag_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .q_ready     (q_not_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   ldpag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   ldpag_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_not_empty      (q_not_empty),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_source_index (rsp_source_index),
      .rsp_target_x     (rsp_target_x),
      .rsp_target_y     (rsp_target_y),
      .rsp_last         (rsp_last),
      .rsp_busy_res     (rsp_busy_res)
   );

   a_we_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> rsp_busy_res)
      else $error("write beat outside a sequence");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_busy_res)
      else $error("last mark outside a sequence");

   a_clipped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |->
         (rsp_source_index == '0) && (rsp_target_x == '0) && (rsp_target_y == '0))
      else $error("clipped beat carries an address");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule
